@@ hdl/rau_pkg.sv @@
package rau_pkg;

   typedef enum logic [1:0] {
      FUNC_ADD = 2'd0,
      FUNC_SUB = 2'd1,
      FUNC_MUL = 2'd2,
      FUNC_DIV = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_ZERO_DEN = 2'd1,
      STATUS_DIV_ZERO = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_SUM,
      ST_GCD,
      ST_DIVN,
      ST_DIVD,
      ST_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic mul;
      logic sum;
      logic gcd_step;
      logic div_start;
      logic div_step;
      logic div_sel_den;
      logic take_num;
      logic take_den;
      logic out_valid;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic early_exit;
      logic num_zero;
      logic gcd_done;
      logic div_done;
   } stat_type;

   localparam int RES_NUM_WIDTH = 33;
   localparam int RES_DEN_WIDTH = 31;

endpackage

@@ hdl/rau_ctrl.sv @@
module rau_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  rau_pkg::stat_type stat,
   output rau_pkg::cmd_type  cmd,
   output logic              busy
);
   import rau_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_MUL;
         end
         ST_MUL: begin
            if (stat.early_exit) state_in = ST_DONE;
            else state_in = ST_SUM;
         end
         ST_SUM: begin
            if (stat.num_zero) state_in = ST_DONE;
            else state_in = ST_GCD;
         end
         ST_GCD: begin
            if (stat.gcd_done) state_in = ST_DIVN;
         end
         ST_DIVN: begin
            if (stat.div_done) state_in = ST_DIVD;
         end
         ST_DIVD: begin
            if (stat.div_done) state_in = ST_DONE;
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ST_MUL: cmd.mul = 1'b1;
         ST_SUM: begin
            cmd.sum       = 1'b1;
            cmd.div_start = ~stat.num_zero;
         end
         ST_GCD: begin
            cmd.gcd_step  = 1'b1;
            cmd.div_start = stat.gcd_done;
         end
         ST_DIVN: begin
            cmd.div_step  = 1'b1;
            cmd.take_num  = stat.div_done;
            cmd.div_start = stat.div_done;
         end
         ST_DIVD: begin
            cmd.div_step    = 1'b1;
            cmd.div_sel_den = 1'b1;
            cmd.take_den    = stat.div_done;
         end
         ST_DONE: cmd.out_valid = 1'b1;
         default: busy = 1'b1;
      endcase
   end

endmodule

@@ hdl/rau_datapath.sv @@
module rau_datapath #(
   parameter int OPERAND_WIDTH = 16
) (
   input  logic                                  clock,
   input  rau_pkg::cmd_type                      cmd,
   input  logic [1:0]                            req_func,
   input  logic signed [OPERAND_WIDTH-1:0]       req_a_num,
   input  logic signed [OPERAND_WIDTH-1:0]       req_a_den,
   input  logic signed [OPERAND_WIDTH-1:0]       req_b_num,
   input  logic signed [OPERAND_WIDTH-1:0]       req_b_den,
   output rau_pkg::stat_type                     stat,
   output logic signed [rau_pkg::RES_NUM_WIDTH-1:0] rsp_res_num,
   output logic [rau_pkg::RES_DEN_WIDTH-1:0]     rsp_res_den,
   output logic [1:0]                            rsp_status
);
   import rau_pkg::*;

   localparam int MW = OPERAND_WIDTH;      // magnitude width
   localparam int PW = 2 * MW;             // product width
   localparam int SW = PW + 1;             // sum width
   localparam int CW = $clog2(SW + 1);
   localparam int XW = (SW > RES_NUM_WIDTH) ? SW : RES_NUM_WIDTH;

   logic [1:0]  func_ff;
   logic [MW-1:0] an_ff, ad_ff, bn_ff, bd_ff;
   logic an_s_ff, ad_s_ff, bn_s_ff, bd_s_ff;
   logic [PW-1:0] p1_ff, p2_ff, pd_ff;
   logic p1_s_ff, p2_s_ff, pd_s_ff;
   logic [SW-1:0] nmag_ff, dmag_ff, ga_ff, gb_ff;
   logic [CW-1:0] gk_ff;
   logic neg_ff;
   logic [1:0] status_ff;
   logic early_ff;

   // restoring divider
   logic [SW-1:0] rem_ff, quo_ff, dvsr_ff;
   logic [CW-1:0] cnt_ff;
   logic [SW-1:0] res_n_ff, res_d_ff;

   function automatic logic [MW-1:0] mag(input logic [MW-1:0] v);
      return v[MW-1] ? (~v + 1'b1) : v;
   endfunction

   logic bn_neg_eff;
   logic [SW-1:0] sum_mag;
   logic sum_neg;
   logic [SW-1:0] x1, x2;

   always_comb begin
      x1 = {1'b0, p1_ff};
      x2 = {1'b0, p2_ff};
      if (p1_s_ff == p2_s_ff) begin
         sum_mag = x1 + x2;
         sum_neg = p1_s_ff;
      end else if (x1 >= x2) begin
         sum_mag = x1 - x2;
         sum_neg = p1_s_ff;
      end else begin
         sum_mag = x2 - x1;
         sum_neg = p2_s_ff;
      end
   end

   assign bn_neg_eff = (func_ff == FUNC_SUB) ? ~bn_s_ff : bn_s_ff;

   logic [SW-1:0] rem_sh, rem_try;
   assign rem_sh  = {rem_ff[SW-2:0], quo_ff[SW-1]};
   assign rem_try = rem_sh - dvsr_ff;

   logic [SW-1:0] gcd_val;
   // restore the common factors of two stripped during the gcd loop
   assign gcd_val = (ga_ff | gb_ff) << gk_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff  <= req_func;
         an_ff    <= mag(req_a_num);
         ad_ff    <= mag(req_a_den);
         bn_ff    <= mag(req_b_num);
         bd_ff    <= mag(req_b_den);
         an_s_ff  <= req_a_num[MW-1];
         ad_s_ff  <= req_a_den[MW-1];
         bn_s_ff  <= req_b_num[MW-1];
         bd_s_ff  <= req_b_den[MW-1];
      end
      if (cmd.mul) begin
         res_n_ff  <= '0;
         res_d_ff  <= '0;
         if (ad_ff == '0 || bd_ff == '0) begin
            early_ff  <= 1'b1;
            status_ff <= STATUS_ZERO_DEN;
         end else if (func_ff == FUNC_DIV && bn_ff == '0) begin
            early_ff  <= 1'b1;
            status_ff <= STATUS_DIV_ZERO;
         end else begin
            early_ff  <= 1'b0;
            status_ff <= STATUS_OK;
         end
         case (func_ff)
            FUNC_MUL: begin
               p1_ff <= an_ff * bn_ff; p1_s_ff <= an_s_ff ^ bn_s_ff;
               pd_ff <= ad_ff * bd_ff; pd_s_ff <= ad_s_ff ^ bd_s_ff;
               p2_ff <= '0; p2_s_ff <= an_s_ff ^ bn_s_ff;
            end
            FUNC_DIV: begin
               p1_ff <= an_ff * bd_ff; p1_s_ff <= an_s_ff ^ bd_s_ff;
               pd_ff <= ad_ff * bn_ff; pd_s_ff <= ad_s_ff ^ bn_s_ff;
               p2_ff <= '0; p2_s_ff <= an_s_ff ^ bd_s_ff;
            end
            default: begin
               p1_ff <= an_ff * bd_ff; p1_s_ff <= an_s_ff ^ bd_s_ff;
               p2_ff <= bn_ff * ad_ff; p2_s_ff <= bn_neg_eff ^ ad_s_ff;
               pd_ff <= ad_ff * bd_ff; pd_s_ff <= ad_s_ff ^ bd_s_ff;
            end
         endcase
      end
      if (cmd.sum) begin
         nmag_ff  <= sum_mag;
         dmag_ff  <= {1'b0, pd_ff};
         neg_ff   <= sum_neg ^ pd_s_ff;
         ga_ff    <= sum_mag;
         gb_ff    <= {1'b0, pd_ff};
         gk_ff    <= '0;
         res_n_ff <= '0;
         res_d_ff <= SW'(1);
      end
      if (cmd.gcd_step && !stat.gcd_done) begin
         // binary gcd: count common twos, halve even values, subtract and halve odd ones
         if (!ga_ff[0] && !gb_ff[0]) begin
            ga_ff <= ga_ff >> 1;
            gb_ff <= gb_ff >> 1;
            gk_ff <= gk_ff + 1'b1;
         end else if (!ga_ff[0]) begin
            ga_ff <= ga_ff >> 1;
         end else if (!gb_ff[0]) begin
            gb_ff <= gb_ff >> 1;
         end else if (ga_ff >= gb_ff) begin
            ga_ff <= (ga_ff - gb_ff) >> 1;
         end else begin
            gb_ff <= (gb_ff - ga_ff) >> 1;
         end
      end
      if (cmd.div_start) begin
         rem_ff  <= '0;
         quo_ff  <= cmd.sum ? sum_mag : (cmd.take_num ? dmag_ff : nmag_ff);
         // hold the gcd divisor for the second division
         dvsr_ff <= cmd.sum ? '0 : (cmd.take_num ? dvsr_ff : gcd_val);
         cnt_ff  <= CW'(SW);
      end else if (cmd.div_step && cnt_ff != '0) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (!rem_try[SW-1] && rem_sh >= dvsr_ff) begin
            rem_ff <= rem_try;
            quo_ff <= {quo_ff[SW-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            quo_ff <= {quo_ff[SW-2:0], 1'b0};
         end
      end
      if (cmd.take_num) res_n_ff <= quo_ff;
      if (cmd.take_den) res_d_ff <= quo_ff;
   end

   assign stat.early_exit = ~(ad_ff != '0 && bd_ff != '0 &&
                              !(func_ff == FUNC_DIV && bn_ff == '0));
   assign stat.num_zero   = (sum_mag == '0);
   assign stat.gcd_done   = (ga_ff == '0) || (gb_ff == '0);
   assign stat.div_done   = (cnt_ff == '0);

   logic [XW-1:0] n_ext, d_ext, n_signed;
   assign n_ext    = XW'(res_n_ff);
   assign d_ext    = XW'(res_d_ff);
   assign n_signed = (neg_ff && !early_ff) ? (~n_ext + 1'b1) : n_ext;
   assign rsp_res_num = n_signed[RES_NUM_WIDTH-1:0];
   assign rsp_res_den = d_ext[RES_DEN_WIDTH-1:0];
   assign rsp_status  = status_ff;
endmodule

@@ hdl/rational_arithmetic_unit.sv @@
// Rational arithmetic: add, subtract, multiply or divide two signed fractions,
// reduced by the gcd, sign in the numerator. A request is taken when start is
// high and busy low; the result shows for one cycle with rsp_valid, which the
// receiver cannot stall. A request passes through the multiply, sum, binary gcd
// and two division states (numerator, then denominator); error cases go to the
// result straight from the multiply state and zero results from the sum state.
// Busy drops the cycle after the result.
module rational_arithmetic_unit #(
   parameter int OPERAND_WIDTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [1:0]                        req_func,
   input  logic signed [OPERAND_WIDTH-1:0]   req_a_num,
   input  logic signed [OPERAND_WIDTH-1:0]   req_a_den,
   input  logic signed [OPERAND_WIDTH-1:0]   req_b_num,
   input  logic signed [OPERAND_WIDTH-1:0]   req_b_den,
   output logic                              rsp_valid,
   output logic signed [32:0]                rsp_res_num,
   output logic [30:0]                       rsp_res_den,
   output logic [1:0]                        rsp_status
);
   import rau_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   rau_ctrl u_ctrl (
      .clock (clock), .reset (reset), .start (start),
      .stat (stat), .cmd (cmd), .busy (busy)
   );

   rau_datapath #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dp (
      .clock (clock), .cmd (cmd),
      .req_func (req_func), .req_a_num (req_a_num), .req_a_den (req_a_den),
      .req_b_num (req_b_num), .req_b_den (req_b_den),
      .stat (stat), .rsp_res_num (rsp_res_num), .rsp_res_den (rsp_res_den),
      .rsp_status (rsp_status)
   );

   assign rsp_valid = cmd.out_valid;
endmodule

@@ hdl/rau_checker.sv @@
module rau_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [30:0] rsp_res_den,
   input logic [1:0]  rsp_status
);
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("request not taken");
   a_valid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result while idle");
   a_valid_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy) else $error("busy after result");
   a_den_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == 2'd0 |-> rsp_res_den != 31'd0)
      else $error("zero denominator on success");
endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
   .clock (clock), .reset (reset), .start (start), .busy (busy),
   .rsp_valid (rsp_valid), .rsp_res_den (rsp_res_den), .rsp_status (rsp_status)
);
